// ===== sv/mte_pkg.sv =====
// Package for the membership table engine: sizes, operation and status codes,
// request, response and entry types, and the control word sent to the cells.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package mte_pkg;

  // Table geometry.
  localparam int unsigned TableDepth = 64;
  localparam int unsigned KeyBits    = 64;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned OccW       = 7;

  // Operation codes carried in the func field.
  typedef enum logic [1:0] {
    FUNC_ADD      = 2'd0,
    FUNC_CONTAINS = 2'd1,
    FUNC_REMOVE   = 2'd2
  } func_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_DUPLICATE = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_COMMIT
  } state_e;

  // One request beat.
  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] node_key;
    logic [31:0] ip_address;
    logic [15:0] port_number;
    logic [31:0] now_time;
  } req_t;

  // One response beat.
  typedef struct packed {
    logic [1:0]      status;
    logic            found;
    logic [OccW-1:0] occupancy;
  } rsp_t;

  // One table entry as held by a cell.
  typedef struct packed {
    logic [KeyBits-1:0] key;
    logic [31:0]        ip_address;
    logic [15:0]        port_number;
    logic [31:0]        heartbeat;
  } entry_t;

  // Control word broadcast to every cell.
  typedef struct packed {
    logic               search;
    logic               insert;
    logic               shift_down;
    logic [CntW-1:0]    count;
    logic [IdxW-1:0]    slot;
    logic [KeyBits-1:0] key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/mte_cell.sv =====
// One cell of the member table: holds a single entry and its match flag.
// Depends on mte_pkg; instantiated in a row by membership_table_engine.
`default_nettype none

module mte_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [mte_pkg::IdxW-1:0] idx_i,
  input  mte_pkg::cell_ctrl_t      ctrl_i,
  input  mte_pkg::entry_t          below_i,
  input  mte_pkg::entry_t          above_i,
  output mte_pkg::entry_t          entry_o,
  output logic                     match_o
);

  mte_pkg::entry_t entry_q, entry_d;
  logic            match_q, match_d;
  logic            in_use;

  // A cell is in use when its position lies below the entry count.
  assign in_use = mte_pkg::CntW'(idx_i) < ctrl_i.count;

  // Inserts push the whole row up by one; removals close the gap from above.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      entry_d = below_i;
    end else if (ctrl_i.shift_down && (idx_i >= ctrl_i.slot)) begin
      entry_d = above_i;
    end
  end

  // The match flag is refreshed during the search cycle only.
  always_comb begin
    match_d = match_q;
    if (ctrl_i.search) begin
      match_d = in_use && (entry_q.key == ctrl_i.key);
    end
  end

  // Entry contents need no reset.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

// ===== sv/mte_ctrl.sv =====
// Sequencer of the member table: request and result registers, entry count,
// match reduction and the control word for the row of cells.
// Depends on mte_pkg; instantiated by membership_table_engine.
`default_nettype none

module mte_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mte_pkg::req_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mte_pkg::rsp_t                  out_data_o,
  input  logic [mte_pkg::TableDepth-1:0] match_i,
  output mte_pkg::cell_ctrl_t            ctrl_o,
  output mte_pkg::entry_t                new_entry_o
);

  mte_pkg::state_e state_q, state_d;
  mte_pkg::req_t   req_q, req_d;
  mte_pkg::rsp_t   out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [mte_pkg::CntW-1:0] count_q, count_d;
  logic [mte_pkg::IdxW-1:0] slot_q, slot_d;
  logic            hit_q, hit_d;

  logic            accept;
  logic            commit;
  logic            do_insert;
  logic            do_remove;
  logic [1:0]      status;
  logic            found;
  logic [mte_pkg::CntW+mte_pkg::OccW-1:0] occ_wide;

  assign accept = in_valid_i && (state_q == mte_pkg::ST_IDLE);
  assign commit = (state_q == mte_pkg::ST_COMMIT) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mte_pkg::ST_IDLE:   if (accept) state_d = mte_pkg::ST_SEARCH;
      mte_pkg::ST_SEARCH: state_d = mte_pkg::ST_DECIDE;
      mte_pkg::ST_DECIDE: state_d = mte_pkg::ST_COMMIT;
      mte_pkg::ST_COMMIT: if (commit) state_d = mte_pkg::ST_IDLE;
      default:            state_d = mte_pkg::ST_IDLE;
    endcase
  end

  // Reduce the match row to a hit flag and a slot; keys are unique in the
  // table, so at most one cell matches and an OR of indices is its slot.
  always_comb begin
    hit_d  = hit_q;
    slot_d = slot_q;
    if (state_q == mte_pkg::ST_DECIDE) begin
      hit_d  = |match_i;
      slot_d = '0;
      for (int i = 0; i < mte_pkg::TableDepth; i++) begin
        if (match_i[i]) begin
          slot_d = slot_d | mte_pkg::IdxW'(i);
        end
      end
    end
  end

  // Decide the outcome of the held request.
  always_comb begin
    status    = mte_pkg::STATUS_OK;
    found     = 1'b0;
    do_insert = 1'b0;
    do_remove = 1'b0;
    case (req_q.func)
      mte_pkg::FUNC_ADD: begin
        if (hit_q) begin
          status = mte_pkg::STATUS_DUPLICATE;
        end else if (count_q == mte_pkg::CntW'(mte_pkg::TableDepth)) begin
          status = mte_pkg::STATUS_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      mte_pkg::FUNC_CONTAINS: begin
        found = hit_q;
      end
      mte_pkg::FUNC_REMOVE: begin
        if (!hit_q) begin
          status = mte_pkg::STATUS_NOT_FOUND;
        end else begin
          do_remove = 1'b1;
        end
      end
      default: begin
        status = mte_pkg::STATUS_OK;
      end
    endcase
  end

  // Count, request and result register updates.
  always_comb begin
    req_d       = req_q;
    count_d     = count_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (accept) begin
      req_d = in_data_i;
    end
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (commit) begin
      if (do_insert) begin
        count_d = count_q + 1'b1;
      end else if (do_remove) begin
        count_d = count_q - 1'b1;
      end
      out_valid_d      = 1'b1;
      out_d.status     = status;
      out_d.found      = found;
      out_d.occupancy  = occ_wide[mte_pkg::OccW-1:0];
    end
  end

  // The occupancy field carries the low bits of the new count.
  assign occ_wide = {{mte_pkg::OccW{1'b0}}, count_d};

  // Outputs towards the ports and the cells.
  always_comb begin
    in_ready_o              = (state_q == mte_pkg::ST_IDLE);
    out_valid_o             = out_valid_q;
    out_data_o              = out_q;
    ctrl_o.search           = (state_q == mte_pkg::ST_SEARCH);
    ctrl_o.insert           = commit && do_insert;
    ctrl_o.shift_down       = commit && do_remove;
    ctrl_o.count            = count_q;
    ctrl_o.slot             = slot_q;
    ctrl_o.key              = req_q.node_key[mte_pkg::KeyBits-1:0];
    new_entry_o.key         = req_q.node_key[mte_pkg::KeyBits-1:0];
    new_entry_o.ip_address  = req_q.ip_address;
    new_entry_o.port_number = req_q.port_number;
    new_entry_o.heartbeat   = req_q.now_time;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mte_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    out_q  <= out_d;
    hit_q  <= hit_d;
    slot_q <= slot_d;
  end

endmodule

`default_nettype wire

// ===== sv/membership_table_engine.sv =====
// Top level of the membership table engine: sequencer plus a row of cells.
// Depends on mte_pkg, mte_cell and mte_ctrl.
`default_nettype none

// Member table of mte_pkg::TableDepth entries keyed by node identifier. Each
// request beat adds, looks up or removes one member and yields exactly one
// response beat with status, found flag and the occupancy after the request.
// A request passes through the states IDLE, in which the beat is taken,
// SEARCH, in which every cell compares its key with the request, DECIDE, which
// reduces the match row to a hit and a slot, and COMMIT, which updates the row
// and loads the response register. The row of cells is the single shared
// resource, so one request is in flight at a time and a new one is taken only
// once the previous one has left COMMIT; a response left waiting holds the next
// request in its COMMIT state. Adds push every entry one cell along the row;
// removals shift the entries above the freed cell down by one. No clearing is
// needed after reset: cells at or above the count are ignored.
module membership_table_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mte_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mte_pkg::rsp_t out_data_o
);

  mte_pkg::cell_ctrl_t            ctrl;
  mte_pkg::entry_t                new_entry;
  mte_pkg::entry_t                entries [mte_pkg::TableDepth];
  logic [mte_pkg::TableDepth-1:0] match;

  mte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .match_i     (match),
    .ctrl_o      (ctrl),
    .new_entry_o (new_entry)
  );

  // Row of cells; each takes from its lower or upper neighbour.
  for (genvar i = 0; i < mte_pkg::TableDepth; i++) begin : g_cell
    mte_pkg::entry_t below;
    mte_pkg::entry_t above;

    if (i == 0) begin : g_first
      assign below = new_entry;
    end else begin : g_inner_lo
      assign below = entries[i-1];
    end

    if (i == mte_pkg::TableDepth - 1) begin : g_last
      assign above = entries[i];
    end else begin : g_inner_hi
      assign above = entries[i+1];
    end

    mte_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (mte_pkg::IdxW'(i)),
      .ctrl_i  (ctrl),
      .below_i (below),
      .above_i (above),
      .entry_o (entries[i]),
      .match_o (match[i])
    );
  end

endmodule

`default_nettype wire

// ===== sv/mte_checker.sv =====
// Port-level checker for membership_table_engine, with its bind statement.
// Depends on mte_pkg and on the top level's port names.
`default_nettype none

module mte_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input mte_pkg::req_t in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input mte_pkg::rsp_t out_data_o
);

  localparam logic [6:0] FullOcc = 7'(mte_pkg::TableDepth);

  // A response beat that is not taken holds steady.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("response beat changed while stalled");

  // Only one request is in flight: taking a beat drops ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // A found flag comes only with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |-> out_data_o.status == mte_pkg::STATUS_OK)
    else $error("found flag with a failing status");

  // Table full is reported only at full occupancy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == mte_pkg::STATUS_FULL)
      |-> out_data_o.occupancy == FullOcc)
    else $error("table full reported below full occupancy");

endmodule

bind membership_table_engine mte_checker u_mte_checker (.*);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the membership table engine: a directed table,
// then random add, contains and remove traffic checked against a key predictor.
// Depends on mte_pkg and membership_table_engine.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ClkPeriod      = 10;
  localparam int          ResetCycles    = 10;
  localparam int          CycleLimit     = 500000;
  localparam int          EndDrainCycles = 16;
  localparam int          RandomItems    = 1630;
  localparam int          SegLen         = 130;
  localparam int          QuietItems     = 150;
  localparam int          PoolSize       = 80;
  // The func field has one code that names no operation.
  localparam logic [1:0]  FuncUnused     = 2'd3;
  localparam logic [63:0] KeyOnes        = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] KeyTopLow      = 64'h8000_0000_0000_0001;
  localparam logic [63:0] KeyLow         = 64'h0000_0000_0000_0001;
  localparam logic [63:0] KeyTop         = 64'h8000_0000_0000_0000;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  mte_pkg::req_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b1;
  mte_pkg::rsp_t  out_data_o;

  // One row of the directed table; want is used only where typed is set.
  typedef struct {
    mte_pkg::req_t beat;
    bit            typed;
    mte_pkg::rsp_t want;
  } directed_row_t;

  directed_row_t                directed_rows[$];
  mte_pkg::rsp_t                pending_answers[$];
  logic [mte_pkg::KeyBits-1:0]  member_keys [mte_pkg::TableDepth];
  int                           live_members  = 0;
  logic [63:0]                  key_pool [PoolSize];
  bit                           idling_on     = 1'b1;
  int                           mismatch_count = 0;
  int                           cycle_count    = 0;

  membership_table_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Hard limit on the run, far above the slowest correct run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Key table predictor. Only the keys and the count decide a response, so the
  // address, port and heartbeat of each member are not kept here.
  function automatic mte_pkg::rsp_t predict_membership(input mte_pkg::req_t beat);
    mte_pkg::rsp_t               answer;
    logic [mte_pkg::KeyBits-1:0] key;
    bit                          hit;
    int                          slot;
    int                          i;
    answer = '0;
    key    = beat.node_key[mte_pkg::KeyBits-1:0];
    hit    = 1'b0;
    slot   = 0;
    for (i = 0; i < live_members; i++) begin
      if (!hit && member_keys[i] == key) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    case (beat.func)
      mte_pkg::FUNC_ADD: begin
        if (hit) begin
          answer.status = mte_pkg::STATUS_DUPLICATE;
        end else if (live_members >= mte_pkg::TableDepth) begin
          answer.status = mte_pkg::STATUS_FULL;
        end else begin
          member_keys[live_members] = key;
          live_members++;
        end
      end
      mte_pkg::FUNC_CONTAINS: begin
        answer.found = hit;
      end
      mte_pkg::FUNC_REMOVE: begin
        if (!hit) begin
          answer.status = mte_pkg::STATUS_NOT_FOUND;
        end else begin
          // The last member fills the freed slot.
          member_keys[slot] = member_keys[live_members - 1];
          live_members--;
        end
      end
      default: begin
      end
    endcase
    answer.occupancy = mte_pkg::OccW'(live_members);
    return answer;
  endfunction

  function automatic directed_row_t dir_row(input logic [1:0] func, input logic [63:0] key,
                                            input logic [31:0] ip, input logic [15:0] port,
                                            input logic [31:0] stamp, input int typed,
                                            input logic [1:0] status, input int found,
                                            input int occ);
    directed_row_t r;
    r.beat.func        = func;
    r.beat.node_key    = key;
    r.beat.ip_address  = ip;
    r.beat.port_number = port;
    r.beat.now_time    = stamp;
    r.typed            = (typed != 0);
    r.want.status      = status;
    r.want.found       = (found != 0);
    r.want.occupancy   = mte_pkg::OccW'(occ);
    return r;
  endfunction

  // Random request. Removes and lookups often target a present member so that
  // hits are common; adds draw from a pool larger than the table so that the
  // table fills and duplicates occur.
  function automatic mte_pkg::req_t make_request(input int add_weight,
                                                 input int remove_weight);
    mte_pkg::req_t beat;
    int            pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      beat.func = FuncUnused;
    end else if (pick < 3 + add_weight) begin
      beat.func = mte_pkg::FUNC_ADD;
    end else if (pick < 3 + add_weight + remove_weight) begin
      beat.func = mte_pkg::FUNC_REMOVE;
    end else begin
      beat.func = mte_pkg::FUNC_CONTAINS;
    end
    pick = $urandom_range(0, 99);
    if (pick < 40 && live_members > 0 && beat.func != mte_pkg::FUNC_ADD) begin
      beat.node_key = member_keys[$urandom_range(0, live_members - 1)];
    end else if (pick < 88) begin
      beat.node_key = key_pool[$urandom_range(0, PoolSize - 1)];
    end else begin
      beat.node_key = {$urandom, $urandom};
    end
    case ($urandom_range(0, 7))
      0: begin
        beat.ip_address  = '0;
        beat.port_number = '0;
        beat.now_time    = '0;
      end
      1: begin
        beat.ip_address  = '1;
        beat.port_number = '1;
        beat.now_time    = '1;
      end
      default: begin
        beat.ip_address  = $urandom;
        beat.port_number = 16'($urandom);
        beat.now_time    = $urandom;
      end
    endcase
    return beat;
  endfunction

  // Offers one request beat and records its expected answer once it is taken.
  // Valid stays high after acceptance; an idle gap, the hold-off or the end lowers it.
  task automatic send_request(input mte_pkg::req_t beat, input bit typed,
                              input mte_pkg::rsp_t want);
    mte_pkg::rsp_t predicted;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = predict_membership(beat);
    pending_answers.push_back(typed ? want : predicted);
  endtask

  // Response side: random stalls while idling is enabled.
  initial begin : response_stalls
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_ready_i <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left  = $urandom_range(1, 13);
        out_ready_i <= 1'b0;
      end
    end
  end

  // Every response beat is compared with the oldest outstanding answer.
  always @(posedge clk_i) begin : response_check
    mte_pkg::rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("response beat with no request outstanding");
      end else begin
        want = pending_answers.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data_o.status, want.status));
        if (out_data_o.found !== want.found)
          report_mismatch($sformatf("found %0b, expected %0b",
                                    out_data_o.found, want.found));
        if (out_data_o.occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, expected %0d",
                                    out_data_o.occupancy, want.occupancy));
      end
    end
  end

  initial begin : stimulus
    int            n;
    int            add_weight;
    int            remove_weight;
    mte_pkg::rsp_t none;
    none = '0;

    key_pool[0] = '0;
    key_pool[1] = KeyOnes;
    for (n = 2; n < PoolSize; n++) key_pool[n] = {$urandom, $urandom};

    // Empty table, extremes of every field, duplicates and the unused code.
    directed_rows.push_back(dir_row(mte_pkg::FUNC_CONTAINS, '0, '0, '0, '0, 1,
                                    mte_pkg::STATUS_OK, 0, 0));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_REMOVE, '0, '0, '0, '0, 1,
                                    mte_pkg::STATUS_NOT_FOUND, 0, 0));
    directed_rows.push_back(dir_row(FuncUnused, KeyOnes, '1, '1, '1, 1,
                                    mte_pkg::STATUS_OK, 0, 0));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_ADD, KeyOnes, '1, '1, '1, 1,
                                    mte_pkg::STATUS_OK, 0, 1));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_ADD, KeyOnes, '0, '0, '0, 1,
                                    mte_pkg::STATUS_DUPLICATE, 0, 1));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_CONTAINS, KeyOnes, '0, '0, '0, 1,
                                    mte_pkg::STATUS_OK, 1, 1));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_ADD, '0, '0, '0, '0, 1,
                                    mte_pkg::STATUS_OK, 0, 2));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_CONTAINS, '0, '1, '1, '1, 1,
                                    mte_pkg::STATUS_OK, 1, 2));
    directed_rows.push_back(dir_row(FuncUnused, '0, '0, '0, '0, 1,
                                    mte_pkg::STATUS_OK, 0, 2));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_REMOVE, KeyOnes, '0, '0, '0, 1,
                                    mte_pkg::STATUS_OK, 0, 1));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_CONTAINS, KeyOnes, '0, '0, '0, 1,
                                    mte_pkg::STATUS_OK, 0, 1));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_REMOVE, '0, '0, '0, '0, 1,
                                    mte_pkg::STATUS_OK, 0, 0));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_REMOVE, '0, '0, '0, '0, 1,
                                    mte_pkg::STATUS_NOT_FOUND, 0, 0));
    // Keys differing only in the top or bottom bit; removing the first member
    // moves the last one into its slot.
    directed_rows.push_back(dir_row(mte_pkg::FUNC_ADD, KeyTopLow, 32'h0a00_0001, 16'd6881,
                                    32'd100, 0, mte_pkg::STATUS_OK, 0, 0));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_ADD, KeyLow, 32'hc0a8_0101, 16'd80,
                                    32'd200, 0, mte_pkg::STATUS_OK, 0, 0));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_ADD, KeyTop, 32'h7f00_0001, 16'd443,
                                    32'd300, 0, mte_pkg::STATUS_OK, 0, 0));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_REMOVE, KeyTopLow, '0, '0, '0, 0,
                                    mte_pkg::STATUS_OK, 0, 0));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_CONTAINS, KeyTop, '0, '0, '0, 0,
                                    mte_pkg::STATUS_OK, 0, 0));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_ADD, KeyTopLow, '1, '0, '1, 0,
                                    mte_pkg::STATUS_OK, 0, 0));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_REMOVE, KeyTop, '0, '0, '0, 0,
                                    mte_pkg::STATUS_OK, 0, 0));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_CONTAINS, KeyLow, '0, '0, '0, 0,
                                    mte_pkg::STATUS_OK, 0, 0));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_REMOVE, KeyLow, '0, '0, '0, 0,
                                    mte_pkg::STATUS_OK, 0, 0));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_REMOVE, KeyTopLow, '0, '0, '0, 0,
                                    mte_pkg::STATUS_OK, 0, 0));
    directed_rows.push_back(dir_row(mte_pkg::FUNC_CONTAINS, KeyTopLow, '0, '0, '0, 0,
                                    mte_pkg::STATUS_OK, 0, 0));

    // Reset is held once, at the start, then released.
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_request(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

    // Random traffic in segments that fill, mix and drain the table in turn.
    add_weight    = 0;
    remove_weight = 0;
    for (n = 0; n < RandomItems; n++) begin
      if (n % SegLen == 0) begin
        case ((n / SegLen) % 3)
          0: begin
            add_weight    = 75;
            remove_weight = 10;
          end
          1: begin
            add_weight    = 35;
            remove_weight = 35;
          end
          default: begin
            add_weight    = 10;
            remove_weight = 75;
          end
        endcase
        idling_on = ($urandom_range(0, 3) != 0);
      end
      if (n >= RandomItems - QuietItems) idling_on = 1'b0;
      // Once in the run the sender holds off until every answer is back.
      if (n == 4 * SegLen) begin
        in_valid_i <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk_i);
      end
      send_request(make_request(add_weight, remove_weight), 1'b0, none);
    end
    in_valid_i <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (EndDrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
